// ----- design/aicp_pkg.sv -----
// ----------------------------------------------------------------------------
// aicp_pkg
// Types, tag constants and helper functions shared by the archive index
// chunk parser modules.
// ----------------------------------------------------------------------------
package aicp_pkg;

   // one input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_type;

   // one result beat
   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] seg_compressed;
      logic [63:0] seg_offset;
      logic [63:0] seg_orig_length;
      logic [63:0] seg_packed_length;
      logic [15:0] name_char;
      logic [31:0] entry_checksum;
      logic [31:0] encrypt_word;
      logic [4:0]  segment_total;
      logic [3:0]  tags_seen;
      logic        format_error;
      logic        last_of_run;
   } out_type;

   // results caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      out_type    rec0;
      out_type    rec1;
   } bundle_type;

   // write side of the bundle queue
   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef enum logic [3:0] {
      PH_HDR  = 4'd0,
      PH_HUNT = 4'd1,
      PH_CHDR = 4'd2,
      PH_ADLR = 4'd3,
      PH_SEGM = 4'd4,
      PH_INFO = 4'd5,
      PH_NAME = 4'd6,
      PH_TAIL = 4'd7,
      PH_FIND = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SEGMENT = 2'd0,
      KIND_NAME    = 2'd1,
      KIND_ENTRY   = 2'd2
   } kind_type;

   localparam logic [31:0] TAG_FILE   = 32'h656C6946;
   localparam logic [31:0] TAG_ADLR   = 32'h726c6461;
   localparam logic [31:0] TAG_SEGM   = 32'h6d676573;
   localparam logic [31:0] TAG_INFO   = 32'h6f666e69;
   localparam logic [31:0] SEG_BYTES  = 32'h1c;
   localparam logic [31:0] INFO_SKIP  = 32'h14;
   localparam logic [31:0] HDR_BYTES  = 32'hc;
   localparam logic [3:0]  ALL_TAGS   = 4'hf;
   localparam logic [32:0] NO_LIMIT   = 33'h1_FFFF_FFFF;
   localparam int          QUEUE_DEPTH = 4;

   // append a record to a bundle, extra records are dropped
   function automatic bundle_type add_rec(input bundle_type bnd, input out_type rec);
      bundle_type res;
      res = bnd;
      if (bnd.count == 2'd0) begin
         res.rec0  = rec;
         res.count = 2'd1;
      end else if (bnd.count == 2'd1) begin
         res.rec1  = rec;
         res.count = 2'd2;
      end
      return res;
   endfunction

   // entry end record
   function automatic out_type entry_rec(input logic [31:0] csum, input logic [31:0] enc,
                                         input logic [4:0] total, input logic [3:0] mask,
                                         input logic err);
      out_type rec;
      rec                = '0;
      rec.record_kind    = KIND_ENTRY;
      rec.entry_checksum = csum;
      rec.encrypt_word   = enc;
      rec.segment_total  = total;
      rec.tags_seen      = mask;
      rec.format_error   = err;
      return rec;
   endfunction

   // length is a whole number of 28-byte segments: mod 4 and mod 7 both zero
   function automatic logic len_mod28_zero(input logic [31:0] len);
      logic [35:0] ext;
      logic [8:0]  s1;
      logic [6:0]  s2;
      logic [6:0]  s3;
      logic [3:0]  s4;
      logic [3:0]  s5;
      ext = {4'b0, len};
      s1  = '0;
      // 64 = 1 mod 7, so six-bit groups add up to the same residue
      for (int i = 0; i < 6; i++) begin
         s1 = s1 + 9'(ext[6*i +: 6]);
      end
      s2 = 7'(s1[5:0]) + 7'(s1[8:6]);
      s3 = 7'(s2[5:0]) + 7'(s2[6]);
      s4 = 4'(s3[2:0]) + 4'(s3[5:3]) + 4'(s3[6]);
      s5 = 4'(s4[2:0]) + 4'(s4[3]);
      return (len[1:0] == 2'b00) && ((s5 == 4'd0) || (s5 == 4'd7));
   endfunction

endpackage

// ----- design/aicp_front.sv -----
// ----------------------------------------------------------------------------
// aicp_front
// Byte parser: tracks the chunk structure of the index, assembles segment,
// name and entry words and hands the results of each byte to the queue.
// ----------------------------------------------------------------------------
module aicp_front #(
   parameter int MAX_SEGMENTS  = 16,
   parameter int NAME_CAPACITY = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  aicp_pkg::in_type req_data,
   input  logic            room,
   output aicp_pkg::push_type push
);
   import aicp_pkg::*;

   localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int NCNT_W = $clog2(NAME_CAPACITY);
   localparam logic [31:0] SEG_LIMIT = 32'(28 * MAX_SEGMENTS);

   logic [31:0] pos_ff, pos_in, win_ff, win_in, cstart_ff, cstart_in, clen_ff, clen_in;
   logic [2:0]  fill_ff, fill_in;
   phase_type   phase_ff, phase_in;
   logic [32:0] eend_ff, eend_in;
   logic [3:0]  mask_ff, mask_in;
   logic [31:0] csum_ff, csum_in, enc_ff, enc_in, rem_ff, rem_in;
   logic [63:0] fa0_ff, fa0_in, fa1_ff, fa1_in, fa2_ff, fa2_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic [NCNT_W-1:0] ncnt_ff, ncnt_in;
   logic [4:0]  kcnt_ff, kcnt_in;
   logic        err_ff, err_in;

   logic        step;
   logic [7:0]  b;
   logic [31:0] r;
   logic [33:0] target;
   logic [33:0] endp;
   logic [15:0] nlen;
   logic        fin;
   phase_type   fin_phase;
   logic        closed;
   bundle_type  bnd;
   out_type     rec;

   assign req_ready = room;
   assign step      = req_valid && room;
   assign push.valid  = step && (bnd.count != 2'd0);
   assign push.bundle = bnd;

   // next state and results for one byte
   always_comb begin
      pos_in = pos_ff; win_in = win_ff; fill_in = fill_ff; phase_in = phase_ff;
      cstart_in = cstart_ff; clen_in = clen_ff; eend_in = eend_ff; mask_in = mask_ff;
      csum_in = csum_ff; enc_in = enc_ff; rem_in = rem_ff;
      fa0_in = fa0_ff; fa1_in = fa1_ff; fa2_in = fa2_ff;
      scnt_in = scnt_ff; ncnt_in = ncnt_ff; kcnt_in = kcnt_ff; err_in = err_ff;
      bnd = '0; rec = '0; fin = 1'b0; fin_phase = PH_HUNT; closed = 1'b0;
      b = req_data.data_byte;
      r = pos_ff - cstart_ff;
      target = 34'(cstart_ff) + 34'(HDR_BYTES) + 34'(clen_ff);
      endp = '0;
      nlen = '0;

      unique case (phase_ff)
         PH_HDR: begin
            if (pos_ff >= 32'd4 && pos_ff < 32'd8) begin
               clen_in[8*pos_ff[1:0] +: 8] = b;
            end
            if (pos_ff >= 32'd8 &&
                (33'(pos_ff) + 33'd1 >= 33'(HDR_BYTES) + 33'(clen_in))) begin
               phase_in = PH_HUNT;
               fill_in  = '0;
               win_in   = '0;
            end
         end
         PH_HUNT: begin
            // entry limit reached at the start of the window
            if ({1'b0, 32'(pos_ff - 32'(fill_ff))} >= eend_ff) begin
               bnd = add_rec(bnd, entry_rec(csum_in, enc_in, 5'(scnt_in), mask_in, err_in));
               mask_in = '0; csum_in = '0; enc_in = '0; scnt_in = '0; err_in = 1'b0;
               eend_in = NO_LIMIT;
            end
            win_in  = {b, win_ff[31:8]};
            fill_in = fill_ff + 3'd1;
            if (fill_in >= 3'd4) begin
               if (win_in == TAG_FILE || win_in == TAG_ADLR ||
                   win_in == TAG_SEGM || win_in == TAG_INFO) begin
                  cstart_in = pos_ff - 32'd3;
                  clen_in   = '0;
                  phase_in  = PH_CHDR;
                  fill_in   = '0;
                  if (win_in == TAG_FILE)      mask_in = mask_in | 4'b0001;
                  else if (win_in == TAG_ADLR) mask_in = mask_in | 4'b0010;
                  else if (win_in == TAG_SEGM) mask_in = mask_in | 4'b0100;
                  else                         mask_in = mask_in | 4'b1000;
               end else begin
                  fill_in = 3'd3;
               end
            end
         end
         PH_FIND: begin
            win_in  = {b, win_ff[31:8]};
            fill_in = fill_ff + 3'd1;
            if (fill_in >= 3'd4) begin
               if (win_in == TAG_FILE) begin
                  if ({1'b0, 32'(pos_ff - 32'd3)} >= eend_ff) begin
                     bnd = add_rec(bnd,
                                   entry_rec(csum_in, enc_in, 5'(scnt_in), mask_in, err_in));
                     mask_in = '0; csum_in = '0; enc_in = '0; scnt_in = '0; err_in = 1'b0;
                     eend_in = NO_LIMIT;
                  end
                  cstart_in = pos_ff - 32'd3;
                  clen_in   = '0;
                  mask_in   = mask_in | 4'b0001;
                  phase_in  = PH_CHDR;
                  fill_in   = '0;
               end else begin
                  fill_in = 3'd3;
               end
            end
         end
         PH_CHDR: begin
            if (r >= 32'd4 && r < 32'd8) begin
               clen_in[8*r[1:0] +: 8] = b;
            end
            // chunk header complete: act on the tag
            if (r >= HDR_BYTES - 32'd1) begin
               if (win_ff == TAG_FILE) begin
                  endp    = 34'(cstart_ff) + 34'(HDR_BYTES) + 34'(clen_in);
                  eend_in = (endp > 34'(NO_LIMIT)) ? NO_LIMIT : 33'(endp);
                  fin     = 1'b1;
               end else if (win_ff == TAG_ADLR) begin
                  csum_in  = '0;
                  phase_in = PH_ADLR;
               end else if (win_ff == TAG_SEGM) begin
                  if (!len_mod28_zero(clen_in)) begin
                     err_in    = 1'b1;
                     fin       = 1'b1;
                     fin_phase = PH_FIND;
                  end else begin
                     scnt_in = '0;
                     rem_in  = clen_in;
                     kcnt_in = '0;
                     if (clen_in > SEG_LIMIT) err_in = 1'b1;
                     if (clen_in == '0) fin = 1'b1;
                     else phase_in = PH_SEGM;
                  end
               end else begin
                  enc_in   = '0;
                  phase_in = PH_INFO;
               end
            end
         end
         PH_ADLR: begin
            if (r >= 32'd12 && r < 32'd16) begin
               csum_in[8*r[1:0] +: 8] = b;
            end
            if (r >= 32'd15) fin = 1'b1;
         end
         PH_SEGM: begin
            if (kcnt_ff == 5'd0) begin
               win_in = '0; fa0_in = '0; fa1_in = '0; fa2_in = '0;
            end
            // byte lanes of compression word, offset, orig and packed length
            if (kcnt_ff < 5'd4)       win_in[8*kcnt_ff[1:0] +: 8] = b;
            else if (kcnt_ff < 5'd12) fa0_in[8*3'(kcnt_ff - 5'd4) +: 8] = b;
            else if (kcnt_ff < 5'd20) fa1_in[8*3'(kcnt_ff - 5'd12) +: 8] = b;
            else                      fa2_in[8*3'(kcnt_ff - 5'd20) +: 8] = b;
            if (32'(kcnt_ff) + 32'd1 < SEG_BYTES) begin
               kcnt_in = kcnt_ff + 5'd1;
            end else begin
               kcnt_in = '0;
               if (scnt_ff < SCNT_W'(MAX_SEGMENTS)) begin
                  rec                   = '0;
                  rec.record_kind       = KIND_SEGMENT;
                  rec.seg_compressed    = win_in;
                  rec.seg_offset        = fa0_in;
                  rec.seg_orig_length   = fa1_in;
                  rec.seg_packed_length = fa2_in;
                  bnd     = add_rec(bnd, rec);
                  scnt_in = scnt_ff + SCNT_W'(1);
               end
               if (rem_ff <= SEG_BYTES) begin
                  rem_in = '0;
                  fin    = 1'b1;
               end else begin
                  rem_in = rem_ff - SEG_BYTES;
               end
            end
         end
         PH_INFO: begin
            if (r >= 32'd12 && r < 32'd16) begin
               enc_in[8*r[1:0] +: 8] = b;
            end
            if (r == HDR_BYTES + INFO_SKIP) fa0_in = 64'(b);
            if (r >= HDR_BYTES + INFO_SKIP + 32'd1) begin
               nlen = {b, fa0_ff[7:0]};
               if (17'(nlen) >= 17'(NAME_CAPACITY)) ncnt_in = NCNT_W'(NAME_CAPACITY - 1);
               else ncnt_in = NCNT_W'(nlen);
               kcnt_in = '0;
               if (ncnt_in == '0) begin
                  if (34'(pos_ff) + 34'd1 >= target) fin = 1'b1;
                  else phase_in = PH_TAIL;
               end else begin
                  phase_in = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            if (kcnt_ff == 5'd0) begin
               fa0_in  = 64'(b);
               kcnt_in = 5'd1;
            end else begin
               rec             = '0;
               rec.record_kind = KIND_NAME;
               rec.name_char   = {b, fa0_ff[7:0]};
               bnd     = add_rec(bnd, rec);
               kcnt_in = '0;
               if (ncnt_ff != '0) ncnt_in = ncnt_ff - NCNT_W'(1);
               if (ncnt_in == '0) begin
                  if (34'(pos_ff) + 34'd1 >= target) fin = 1'b1;
                  else phase_in = PH_TAIL;
               end
            end
         end
         PH_TAIL: begin
            if (34'(pos_ff) + 34'd1 >= target) fin = 1'b1;
            else phase_in = PH_TAIL;
         end
         default: begin
            phase_in = PH_HUNT;
            fill_in  = '0;
            win_in   = '0;
         end
      endcase

      // chunk finished: back to hunt or file tag search, close a complete entry
      if (fin) begin
         phase_in = fin_phase;
         fill_in  = '0;
         win_in   = '0;
         if (mask_in == ALL_TAGS) begin
            bnd = add_rec(bnd, entry_rec(csum_in, enc_in, 5'(scnt_in), mask_in, err_in));
            mask_in = '0; csum_in = '0; enc_in = '0; scnt_in = '0; err_in = 1'b0;
            eend_in = NO_LIMIT;
            closed  = 1'b1;
         end
      end

      pos_in = pos_ff + 32'd1;

      // final byte closes the open entry and restarts the parser
      if (req_data.last_byte) begin
         if (phase_ff != PH_HDR && !closed) begin
            bnd = add_rec(bnd, entry_rec(csum_in, enc_in, 5'(scnt_in), mask_in, err_in));
         end
         pos_in = '0; win_in = '0; fill_in = '0; phase_in = PH_HDR;
         cstart_in = '0; clen_in = '0; eend_in = NO_LIMIT; mask_in = '0;
         csum_in = '0; enc_in = '0; rem_in = '0;
         fa0_in = '0; fa1_in = '0; fa2_in = '0;
         scnt_in = '0; ncnt_in = '0; kcnt_in = '0; err_in = 1'b0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; win_ff <= '0; fill_ff <= '0; phase_ff <= PH_HDR;
         cstart_ff <= '0; clen_ff <= '0; eend_ff <= NO_LIMIT; mask_ff <= '0;
         csum_ff <= '0; enc_ff <= '0; rem_ff <= '0;
         fa0_ff <= '0; fa1_ff <= '0; fa2_ff <= '0;
         scnt_ff <= '0; ncnt_ff <= '0; kcnt_ff <= '0; err_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in; win_ff <= win_in; fill_ff <= fill_in; phase_ff <= phase_in;
         cstart_ff <= cstart_in; clen_ff <= clen_in; eend_ff <= eend_in; mask_ff <= mask_in;
         csum_ff <= csum_in; enc_ff <= enc_in; rem_ff <= rem_in;
         fa0_ff <= fa0_in; fa1_ff <= fa1_in; fa2_ff <= fa2_in;
         scnt_ff <= scnt_in; ncnt_ff <= ncnt_in; kcnt_ff <= kcnt_in; err_ff <= err_in;
      end
   end

endmodule

// ----- design/aicp_queue.sv -----
// ----------------------------------------------------------------------------
// aicp_queue
// Queue of per-byte result bundles and the output stage that sends their
// records one beat at a time.
// ----------------------------------------------------------------------------
module aicp_queue (
   input  logic               clock,
   input  logic               reset,
   input  aicp_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output aicp_pkg::out_type  rsp_data
);
   import aicp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type mem [QUEUE_DEPTH];
   bundle_type hold_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic       hold_valid_ff, hold_valid_in;
   logic       sel_ff, sel_in;
   logic       last_rec, emit_done, load;

   // last record of the held bundle
   assign last_rec  = sel_ff || (hold_ff.count == 2'd1);
   assign emit_done = hold_valid_ff && rsp_ready && last_rec;
   assign load      = (cnt_ff != '0) && (!hold_valid_ff || emit_done);
   assign room      = (cnt_ff != CNT_W'(QUEUE_DEPTH));

   // output beat
   always_comb begin
      rsp_valid = hold_valid_ff;
      rsp_data  = sel_ff ? hold_ff.rec1 : hold_ff.rec0;
      rsp_data.last_of_run = last_rec;
   end

   // pointers, fill and output control
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = load ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push.valid) - CNT_W'(load);
      if (load) begin
         hold_valid_in = 1'b1;
         sel_in        = 1'b0;
      end else if (emit_done) begin
         hold_valid_in = 1'b0;
         sel_in        = 1'b0;
      end else if (hold_valid_ff && rsp_ready) begin
         hold_valid_in = 1'b1;
         sel_in        = 1'b1;
      end else begin
         hold_valid_in = hold_valid_ff;
         sel_in        = sel_ff;
      end
   end

   // bundle storage with registered read
   always_ff @(posedge clock) begin
      if (push.valid) mem[wr_ptr_ff] <= push.bundle;
      if (load) hold_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         sel_ff        <= sel_in;
      end
   end

endmodule

// ----- design/archive_index_chunk_parser_unit.sv -----
// Takes one index byte per clock cycle. Each byte is parsed in the cycle it
// is accepted; the one or two records it causes go as one bundle into a
// four-deep queue. The output stage sends one record per cycle while the
// result side is ready, out of a hold register loaded from the queue memory.
// The input stalls only while the queue is full, which happens only when
// bytes causing two records outrun the output or the result side holds off.
// ----------------------------------------------------------------------------
// archive_index_chunk_parser_unit
// Top level: byte parser in front, result queue and output stage behind.
// ----------------------------------------------------------------------------
module archive_index_chunk_parser_unit #(
   parameter int MAX_SEGMENTS  = 16,
   parameter int NAME_CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aicp_pkg::in_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aicp_pkg::out_type rsp_data
);
   import aicp_pkg::*;

   push_type push;
   logic     room;

   // parser
   aicp_front #(
      .MAX_SEGMENTS  (MAX_SEGMENTS),
      .NAME_CAPACITY (NAME_CAPACITY)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   // result queue
   aicp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/archive_index_chunk_parser_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// archive_index_chunk_parser_unit_tb
// Streams archive index byte beats into the parser and checks every record
// against an in-bench parser model. Directed streams go first: a full entry,
// a bad segment length, segment overflow, long and short names, a stream cut
// in its header and a repeated tag. Random streams follow, made of mostly
// well-formed entries with random content, plus noise and truncated streams.
// ----------------------------------------------------------------------------
module archive_index_chunk_parser_unit_tb;
   import aicp_pkg::*;

   localparam int SEG_CAP   = 16;
   localparam int NAME_CAP  = 256;
   localparam int RAND_BYTES = 150;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   in_type  req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   out_type rsp_data;

   archive_index_chunk_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   in_type     byte_q[$];
   out_type    record_q[$];
   logic [7:0] stream_buf[$];
   int         n_fail = 0;
   int         n_sent = 0;
   int         cycles = 0;

   // parser model state
   logic [31:0] pos_r, win, cstart, clen, csum, enc;
   logic [31:0] seg_stored, seg_left;
   logic [15:0] names_left, kcnt;
   logic [2:0]  fill;
   logic [3:0]  mask;
   logic        err, closed;
   logic [32:0] end_pos;
   logic [63:0] words[3];
   phase_type   ph;
   out_type     outs[2];
   int          n_out;

   task emit(input out_type r);
      if (n_out < 2) begin
         outs[n_out] = r;
         n_out++;
      end
   endtask

   task clear_entry_regs();
      mask = '0; csum = '0; enc = '0; seg_stored = '0; err = 1'b0;
      end_pos = NO_LIMIT;
   endtask

   task close_entry_rec();
      out_type r;
      r = '0;
      r.record_kind    = KIND_ENTRY;
      r.entry_checksum = csum;
      r.encrypt_word   = enc;
      r.segment_total  = seg_stored[4:0];
      r.tags_seen      = mask;
      r.format_error   = err;
      emit(r);
      clear_entry_regs();
   endtask

   task end_chunk();
      ph = PH_HUNT; fill = '0; win = '0;
      if (mask == ALL_TAGS) begin
         close_entry_rec();
         closed = 1'b1;
      end
   endtask

   task skip_to_chunk_end();
      if ({2'b0, pos_r} + 34'd1 >= {2'b0, cstart} + 34'd12 + {2'b0, clen}) end_chunk();
      else ph = PH_TAIL;
   endtask

   task open_chunk(input logic [3:0] tag_bit);
      cstart = pos_r - 32'd3; clen = '0; mask |= tag_bit; ph = PH_CHDR; fill = '0;
   endtask

   task parser_reset();
      pos_r = '0; win = '0; fill = '0; ph = PH_HDR; cstart = '0; clen = '0;
      words[0] = '0; words[1] = '0; words[2] = '0;
      seg_left = '0; names_left = '0; kcnt = '0;
      clear_entry_regs();
   endtask

   // one accepted byte: update the model and queue the records it causes
   task parse_byte(input in_type it);
      logic [7:0]  b;
      logic [31:0] r, n, k;
      logic [33:0] lim;
      phase_type   ph0;
      out_type     x;
      b = it.data_byte; r = pos_r - cstart; ph0 = ph; n_out = 0; closed = 1'b0;
      case (ph)
         PH_HDR: begin
            if (pos_r >= 4 && pos_r < 8) clen |= {24'b0, b} << (8 * (pos_r - 4));
            if (pos_r >= 8 && {2'b0, pos_r} + 34'd1 >= 34'd12 + {2'b0, clen}) begin
               ph = PH_HUNT; fill = '0; win = '0;
            end
         end
         PH_HUNT: begin
            if ({1'b0, pos_r - {29'b0, fill}} >= end_pos) close_entry_rec();
            win = {b, win[31:8]}; fill++;
            if (fill >= 4) begin
               if (win == TAG_FILE) open_chunk(4'h1);
               else if (win == TAG_ADLR) open_chunk(4'h2);
               else if (win == TAG_SEGM) open_chunk(4'h4);
               else if (win == TAG_INFO) open_chunk(4'h8);
               else fill = 3'd3;
            end
         end
         PH_FIND: begin
            win = {b, win[31:8]}; fill++;
            if (fill >= 4) begin
               if (win == TAG_FILE) begin
                  if ({1'b0, pos_r - 32'd3} >= end_pos) close_entry_rec();
                  open_chunk(4'h1);
               end else fill = 3'd3;
            end
         end
         PH_CHDR: begin
            if (r >= 4 && r < 8) clen |= {24'b0, b} << (8 * (r - 4));
            if (r >= 11) begin
               case (win)
                  TAG_FILE: begin
                     lim = {2'b0, cstart} + 34'd12 + {2'b0, clen};
                     end_pos = (lim > {1'b0, NO_LIMIT}) ? NO_LIMIT : lim[32:0];
                     end_chunk();
                  end
                  TAG_ADLR: begin
                     csum = '0; ph = PH_ADLR;
                  end
                  TAG_SEGM: begin
                     if (clen % 28 != 0) begin
                        err = 1'b1; ph = PH_FIND; fill = '0; win = '0;
                        if (mask == ALL_TAGS) begin
                           close_entry_rec();
                           closed = 1'b1;
                        end
                     end else begin
                        seg_left = clen / 28; seg_stored = '0; kcnt = '0;
                        if (seg_left > SEG_CAP) err = 1'b1;
                        if (seg_left == 0) end_chunk();
                        else ph = PH_SEGM;
                     end
                  end
                  default: begin
                     enc = '0; ph = PH_INFO;
                  end
               endcase
            end
         end
         PH_ADLR: begin
            if (r >= 12 && r < 16) csum |= {24'b0, b} << (8 * (r - 12));
            if (r >= 15) end_chunk();
         end
         PH_SEGM: begin
            k = {16'b0, kcnt};
            if (k == 0) begin
               win = '0; words[0] = '0; words[1] = '0; words[2] = '0;
            end
            if (k < 4) win |= {24'b0, b} << (8 * k);
            else if (k < 12) words[0] |= {56'b0, b} << (8 * (k - 4));
            else if (k < 20) words[1] |= {56'b0, b} << (8 * (k - 12));
            else words[2] |= {56'b0, b} << (8 * (k - 20));
            if (k + 1 < 28) kcnt = kcnt + 16'd1;
            else begin
               kcnt = '0;
               if (seg_stored < SEG_CAP) begin
                  x = '0;
                  x.record_kind       = KIND_SEGMENT;
                  x.seg_compressed    = win;
                  x.seg_offset        = words[0];
                  x.seg_orig_length   = words[1];
                  x.seg_packed_length = words[2];
                  emit(x);
                  seg_stored++;
               end
               if (seg_left > 0) seg_left--;
               if (seg_left == 0) end_chunk();
            end
         end
         PH_INFO: begin
            if (r >= 12 && r < 16) enc |= {24'b0, b} << (8 * (r - 12));
            if (r == 32) words[0] = {56'b0, b};
            if (r >= 33) begin
               n = {16'b0, b, words[0][7:0]};
               if (n >= NAME_CAP) n = NAME_CAP - 1;
               names_left = n[15:0]; kcnt = '0;
               if (n == 0) skip_to_chunk_end();
               else ph = PH_NAME;
            end
         end
         PH_NAME: begin
            if (kcnt == 0) begin
               words[0] = {56'b0, b}; kcnt = 16'd1;
            end else begin
               x = '0;
               x.record_kind = KIND_NAME;
               x.name_char   = {b, words[0][7:0]};
               emit(x);
               kcnt = '0;
               if (names_left > 0) names_left--;
               if (names_left == 0) skip_to_chunk_end();
            end
         end
         PH_TAIL: skip_to_chunk_end();
         default: begin
            ph = PH_HUNT; fill = '0; win = '0;
         end
      endcase
      pos_r = pos_r + 32'd1;
      if (it.last_byte) begin
         if (ph0 != PH_HDR && !closed) close_entry_rec();
         parser_reset();
      end
      if (n_out > 0) outs[n_out - 1].last_of_run = 1'b1;
      for (int i = 0; i < n_out; i++) record_q.insert(record_q.size(), outs[i]);
   endtask

   // ---------------- stream building ----------------

   task put_le(input logic [63:0] v, input int nb);
      for (int i = 0; i < nb; i++) stream_buf.insert(stream_buf.size(), v[8*i +: 8]);
   endtask

   // random byte, sometimes pinned at the extremes
   function automatic logic [7:0] rnd_byte();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'hff;
      if (sel == 1) return 8'h00;
      return 8'($urandom);
   endfunction

   task put_chunk_len(input logic [31:0] len);
      put_le({($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'h0, len}, 8);
   endtask

   task put_header(input int len);
      put_le(32'($urandom), 4);
      put_chunk_len(len);
      for (int i = 0; i < len; i++) stream_buf.insert(stream_buf.size(), rnd_byte());
   endtask

   task put_segm(input int nseg, input bit bad);
      int len;
      len = 28 * nseg + (bad ? $urandom_range(1, 27) : 0);
      put_le(TAG_SEGM, 4);
      put_chunk_len(len);
      for (int i = 0; i < len; i++) stream_buf.insert(stream_buf.size(), rnd_byte());
   endtask

   task put_info(input int nl, input bit short_len);
      int len;
      len = short_len ? $urandom_range(0, 21) : 22 + 2 * nl;
      put_le(TAG_INFO, 4);
      put_chunk_len(len);
      put_le(32'($urandom), 4);
      for (int i = 0; i < 16; i++) stream_buf.insert(stream_buf.size(), rnd_byte());
      put_le(nl, 2);
      for (int i = 0; i < 2 * nl; i++) stream_buf.insert(stream_buf.size(), rnd_byte());
   endtask

   task put_adlr();
      put_le(TAG_ADLR, 4);
      put_chunk_len(4);
      put_le(32'($urandom), 4);
   endtask

   // file chunk followed by its sub-chunks; present selects adlr, segm, info
   task put_entry(input logic [2:0] present, input int nseg, input bit bad,
                  input int nl, input bit short_len, input int skew);
      int len;
      len = (present[0] ? 16 : 0) + (present[1] ? 12 + 28 * nseg : 0)
          + (present[2] ? 34 + 2 * nl : 0) + skew;
      if (len < 0) len = 0;
      put_le(TAG_FILE, 4);
      put_chunk_len(len);
      if (present[0]) put_adlr();
      if (present[1]) put_segm(nseg, bad);
      if (present[2]) put_info(nl, short_len);
   endtask

   // move the built stream to the send queue, last beat flagged
   task flush_stream();
      in_type it;
      while (stream_buf.size() > 0) begin
         it.data_byte = stream_buf.pop_front();
         it.last_byte = (stream_buf.size() == 0);
         byte_q.insert(byte_q.size(), it);
      end
   endtask

   task wait_drained();
      while (byte_q.size() != 0 || req_valid || record_q.size() != 0) @(posedge clock);
   endtask

   // ---------------- driver ----------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data);
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_data  <= byte_q.pop_front();
               req_valid <= 1'b1;
               if (byte_q.size() > 150 && $urandom_range(0, 14) == 0)
                  send_gap = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   int  recv_gap = 0;
   int  long_hold = 0;
   bit  long_done = 0;

   function automatic bit field_bad(input string nm, input logic [63:0] e,
                                    input logic [63:0] a);
      if (e === a) return 1'b0;
      if (n_fail < 10) $display("  %s expected %h got %h", nm, e, a);
      return 1'b1;
   endfunction

   task check_record(input out_type a);
      out_type e;
      bit      bad;
      if (record_q.size() == 0) begin
         if (n_fail < 10) $display("unexpected record %h", a);
         n_fail++;
      end else begin
         e = record_q.pop_front();
         bad = 1'b0;
         bad |= field_bad("record_kind", e.record_kind, a.record_kind);
         bad |= field_bad("seg_compressed", e.seg_compressed, a.seg_compressed);
         bad |= field_bad("seg_offset", e.seg_offset, a.seg_offset);
         bad |= field_bad("seg_orig_length", e.seg_orig_length, a.seg_orig_length);
         bad |= field_bad("seg_packed_length", e.seg_packed_length, a.seg_packed_length);
         bad |= field_bad("name_char", e.name_char, a.name_char);
         bad |= field_bad("entry_checksum", e.entry_checksum, a.entry_checksum);
         bad |= field_bad("encrypt_word", e.encrypt_word, a.encrypt_word);
         bad |= field_bad("segment_total", e.segment_total, a.segment_total);
         bad |= field_bad("tags_seen", e.tags_seen, a.tags_seen);
         bad |= field_bad("format_error", e.format_error, a.format_error);
         bad |= field_bad("last_of_run", e.last_of_run, a.last_of_run);
         if (bad) n_fail++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_record(rsp_data);
         // one long hold-off so the result queue fills and the input stalls
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (!long_done && n_sent >= 400) begin
            long_done = 1;
            long_hold = 300;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (byte_q.size() > 150 && $urandom_range(0, 11) == 0)
               recv_gap = $urandom_range(1, 3);
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------- stimulus and verdict ----------------
   initial begin
      int rand_count;
      int kind;
      parser_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // complete entry, then a second entry closed by the last byte
      put_header(0);
      put_entry(3'b111, 2, 1'b0, 3, 1'b0, 0);
      put_entry(3'b011, 1, 1'b0, 0, 1'b0, 0);
      flush_stream();
      // bad segment length, search resumes at the next file tag
      put_header(3);
      put_entry(3'b111, 1, 1'b1, 1, 1'b0, 0);
      put_entry(3'b111, 0, 1'b0, 1, 1'b0, 0);
      flush_stream();
      // segment overflow
      put_header(1);
      put_entry(3'b111, SEG_CAP + 1, 1'b0, 2, 1'b0, 0);
      flush_stream();
      // name longer than capacity, then a short info length
      put_header(0);
      put_entry(3'b101, 0, 1'b0, 256, 1'b0, 0);
      put_entry(3'b100, 0, 1'b0, 4, 1'b1, 0);
      flush_stream();
      // stream cut inside its header
      put_le(32'($urandom), 3);
      flush_stream();
      // repeated checksum and segment chunks in one entry
      put_header(2);
      put_le(TAG_FILE, 4);
      put_chunk_len(200);
      put_adlr();
      put_adlr();
      put_segm(1, 1'b0);
      put_segm(2, 1'b0);
      put_info(2, 1'b0);
      flush_stream();
      // sender holds until every record has come back
      wait_drained();

      rand_count = 0;
      while (rand_count < RAND_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise
            repeat ($urandom_range(1, 40)) stream_buf.insert(stream_buf.size(), rnd_byte());
         end else begin
            put_header($urandom_range(0, 6));
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0)
                  stream_buf.insert(stream_buf.size(), rnd_byte());
               put_entry(($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111,
                         ($urandom_range(0, 40) == 0) ? SEG_CAP + 1 : $urandom_range(0, 3),
                         $urandom_range(0, 9) == 0,
                         ($urandom_range(0, 80) == 0) ? 256 + $urandom_range(0, 20)
                                                      : $urandom_range(0, 6),
                         $urandom_range(0, 12) == 0,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) - 20 : 0);
            end
            // truncated stream or trailing junk
            if (kind == 1 && stream_buf.size() > 10)
               repeat ($urandom_range(1, 10)) void'(stream_buf.pop_back());
            else if (kind == 2)
               repeat ($urandom_range(1, 6)) stream_buf.insert(stream_buf.size(), rnd_byte());
         end
         rand_count += stream_buf.size();
         flush_stream();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (n_fail == 0 && record_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/aicp_pkg.sv
design/aicp_front.sv
design/aicp_queue.sv
design/archive_index_chunk_parser_unit.sv
verif/archive_index_chunk_parser_unit_tb.sv
